[sv/grid_sph_density_unit_defines.svh]
// Assertion macros shared by the grid density unit checker.
`ifndef GRID_SPH_DENSITY_UNIT_DEFINES_SVH
`define GRID_SPH_DENSITY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gsd_pkg.sv]
// Shared constants and types of the grid density unit.
package gsd_pkg;

  localparam int COORD_W = 7;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W = 29;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 128;
  localparam int RADIUS_DEF = 10;
  localparam logic [31:0] SCALE_Q32_DEF = 32'd54685;

  localparam logic [SUM_W-1:0] OUT_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 1'b1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Control that travels with each visited window cell.
  typedef struct packed {
    logic clr;
    logic hit;
    logic last;
  } cell_ctl_t;

endpackage

[sv/gsd_grid_mem.sv]
// Row-organized occupancy memory, one write and one registered read port.
module gsd_grid_mem #(
  parameter int MAX_COLS = gsd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gsd_pkg::MAX_ROWS_DEF,
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ROW_W-1:0]    rd_addr,
  output logic [MAX_COLS-1:0] rd_data,
  input  logic                wr_en,
  input  logic [ROW_W-1:0]    wr_addr,
  input  logic [MAX_COLS-1:0] wr_data
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/gsd_window_seq.sv]
// Sequencer: grid clearing, cell write read-modify-write and window scan.
module gsd_window_seq #(
  parameter int MAX_COLS = gsd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gsd_pkg::MAX_ROWS_DEF,
  parameter int RADIUS   = gsd_pkg::RADIUS_DEF,
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int T_W     = $clog2(RADIUS * RADIUS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [gsd_pkg::COORD_W-1:0]  in_x_coord,
  input  logic [gsd_pkg::COORD_W-1:0]  in_y_coord,
  input  logic                         in_occupied,
  input  logic [gsd_pkg::CFG_W-1:0]    cols_used,
  input  logic [gsd_pkg::CFG_W-1:0]    rows_used,
  input  logic                         res_done,
  output logic                         mem_rd_en,
  output logic [ROW_W-1:0]             mem_rd_addr,
  input  logic [MAX_COLS-1:0]          mem_rd_data,
  output logic                         mem_wr_en,
  output logic [ROW_W-1:0]             mem_wr_addr,
  output logic [MAX_COLS-1:0]          mem_wr_data,
  output gsd_pkg::cell_ctl_t           cell_ctl,
  output logic [T_W-1:0]               cell_term
);

  localparam int COORD_W = gsd_pkg::COORD_W;
  localparam int CFG_W   = gsd_pkg::CFG_W;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int OFF_W   = $clog2(RADIUS + 1) + 1;
  localparam int MAG_W   = OFF_W - 1;
  localparam int R2      = RADIUS * RADIUS;
  localparam int D2_W    = $clog2(2 * R2 + 1);
  localparam int POS_W0  = (COORD_W > OFF_W) ? COORD_W : OFF_W;
  localparam int POS_W   = ((POS_W0 > CFG_W) ? POS_W0 : CFG_W) + 2;

  localparam logic signed [OFF_W-1:0] OFF_MAX = OFF_W'(RADIUS);
  localparam logic signed [OFF_W-1:0] OFF_MIN = OFF_W'(-RADIUS);
  localparam logic [D2_W-1:0]         R2_D    = D2_W'(R2);
  localparam logic [ROW_W-1:0]        LAST_ROW = ROW_W'(MAX_ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_READ,
    ST_WR_WRITE,
    ST_Q_ISSUE,
    ST_Q_WAIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ROW_W-1:0]         clr_row_r, clr_row_nxt;
  logic [COORD_W-1:0]       cx_r, cx_nxt;
  logic [COORD_W-1:0]       cy_r, cy_nxt;
  logic                     occ_r, occ_nxt;
  logic                     wr_ok_r, wr_ok_nxt;
  logic signed [OFF_W-1:0]  dx_r, dx_nxt;
  logic signed [OFF_W-1:0]  dy_r, dy_nxt;
  logic                     v1_r, v1_nxt;
  logic                     last1_r, last1_nxt;
  logic [COL_W-1:0]         col1_r, col1_nxt;
  logic [D2_W-1:0]          d2_1_r, d2_1_nxt;

  logic signed [POS_W-1:0]  x_pos, y_pos;
  logic                     x_in, y_in, last_cell, accept, in_store;
  logic [MAG_W-1:0]         adx, ady;
  logic [2*MAG_W-1:0]       sq_x, sq_y;
  logic [D2_W-1:0]          d2, t_full;
  logic [MAX_COLS-1:0]      row_mod;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    x_pos = POS_W'({1'b0, cx_r}) + POS_W'(dx_r);
    y_pos = POS_W'({1'b0, cy_r}) + POS_W'(dy_r);
    x_in  = !x_pos[POS_W-1] && (x_pos[POS_W-2:0] < (POS_W-1)'(cols_used));
    y_in  = !y_pos[POS_W-1] && (y_pos[POS_W-2:0] < (POS_W-1)'(rows_used));
    adx   = dx_r[OFF_W-1] ? MAG_W'(-dx_r) : MAG_W'(dx_r);
    ady   = dy_r[OFF_W-1] ? MAG_W'(-dy_r) : MAG_W'(dy_r);
    sq_x  = adx * adx;
    sq_y  = ady * ady;
    d2    = D2_W'(sq_x) + D2_W'(sq_y);
    last_cell = (dx_r == OFF_MAX) && (dy_r == OFF_MAX);
    in_store  = (32'(in_x_coord) < 32'(MAX_COLS)) && (32'(in_y_coord) < 32'(MAX_ROWS));
  end

  // The write path replaces one bit of the row read in the previous cycle.
  always_comb begin
    row_mod = mem_rd_data;
    row_mod[COL_W'(cx_r)] = occ_r;
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = ROW_W'(cy_r);
    mem_wr_en   = 1'b0;
    mem_wr_addr = ROW_W'(cy_r);
    mem_wr_data = row_mod;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_row_r;
        mem_wr_data = '0;
      end
      ST_WR_READ: begin
        mem_rd_en = wr_ok_r;
      end
      ST_WR_WRITE: begin
        mem_wr_en = wr_ok_r;
      end
      ST_Q_ISSUE: begin
        mem_rd_en   = x_in && y_in;
        mem_rd_addr = ROW_W'(y_pos);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    occ_nxt     = occ_r;
    wr_ok_nxt   = wr_ok_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    v1_nxt      = (state_r == ST_Q_ISSUE) && x_in && y_in;
    last1_nxt   = (state_r == ST_Q_ISSUE) && last_cell;
    col1_nxt    = COL_W'(x_pos);
    d2_1_nxt    = d2;
    case (state_r)
      ST_CLEAR: begin
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cx_nxt    = in_x_coord;
          cy_nxt    = in_y_coord;
          occ_nxt   = in_occupied;
          wr_ok_nxt = in_store;
          dx_nxt    = OFF_MIN;
          dy_nxt    = OFF_MIN;
          state_nxt = (in_mode == gsd_pkg::MODE_QUERY) ? ST_Q_ISSUE : ST_WR_READ;
        end
      end
      ST_WR_READ: begin
        state_nxt = ST_WR_WRITE;
      end
      ST_WR_WRITE: begin
        state_nxt = ST_IDLE;
      end
      ST_Q_ISSUE: begin
        if (dx_r == OFF_MAX) begin
          dx_nxt = OFF_MIN;
          dy_nxt = dy_r + 1'b1;
        end else begin
          dx_nxt = dx_r + 1'b1;
        end
        if (last_cell) begin
          state_nxt = ST_Q_WAIT;
        end
      end
      ST_Q_WAIT: begin
        if (res_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_row_r <= '0;
      v1_r      <= 1'b0;
      last1_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      v1_r      <= v1_nxt;
      last1_r   <= last1_nxt;
    end
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    occ_r  <= occ_nxt;
    wr_ok_r <= wr_ok_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    col1_r <= col1_nxt;
    d2_1_r <= d2_1_nxt;
  end

  // Cells are aligned here with the row data returned by the memory.
  assign t_full        = R2_D - d2_1_r;
  assign cell_term     = t_full[T_W-1:0];
  assign cell_ctl.clr  = accept && (in_mode == gsd_pkg::MODE_QUERY);
  assign cell_ctl.hit  = v1_r && (d2_1_r <= R2_D) && mem_rd_data[col1_r];
  assign cell_ctl.last = last1_r;

endmodule

[sv/gsd_accum.sv]
// Kernel cube pipeline, saturating sum and fixed-point density scaling.
module gsd_accum #(
  parameter int          RADIUS    = gsd_pkg::RADIUS_DEF,
  parameter logic [31:0] SCALE_Q32 = gsd_pkg::SCALE_Q32_DEF,
  localparam int         T_W       = $clog2(RADIUS * RADIUS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gsd_pkg::cell_ctl_t         cell_ctl,
  input  logic [T_W-1:0]             cell_term,
  output logic                       out_valid,
  output logic [gsd_pkg::SUM_W-1:0]  out_weight_sum,
  output logic [gsd_pkg::SUM_W-1:0]  out_density_fixed
);

  localparam int SUM_W = gsd_pkg::SUM_W;
  localparam int P_W   = SUM_W + 16;

  logic                 h2_r, l2_r, h3_r, l3_r, fin_r, mul_v_r, out_valid_r;
  logic [T_W-1:0]       t_r;
  logic [2*T_W-1:0]     t2_r, t2_nxt;
  logic [3*T_W-1:0]     cube_r, cube_nxt;
  logic [SUM_W-1:0]     acc_r, acc_nxt;
  logic [SUM_W:0]       acc_sum;
  logic [P_W-1:0]       p_lo_r, p_hi_r, p_lo_nxt, p_hi_nxt;
  logic [SUM_W-1:0]     sum_r;
  logic [P_W:0]         dens_full;
  logic [SUM_W-1:0]     ws_r, dens_r, dens_nxt;

  assign t2_nxt   = cell_term * cell_term;
  assign cube_nxt = t2_r * t_r;
  assign acc_sum  = (SUM_W+1)'(acc_r) + (SUM_W+1)'(cube_r);

  always_comb begin
    acc_nxt = acc_r;
    if (cell_ctl.clr) begin
      acc_nxt = '0;
    end else if (h3_r) begin
      acc_nxt = (acc_sum > (SUM_W+1)'(gsd_pkg::OUT_MAX)) ? gsd_pkg::OUT_MAX
                                                         : acc_sum[SUM_W-1:0];
    end
  end

  // The 32-bit scale is applied as two 16-bit halves to keep multipliers narrow.
  assign p_lo_nxt  = acc_r * SCALE_Q32[15:0];
  assign p_hi_nxt  = acc_r * SCALE_Q32[31:16];
  assign dens_full = (P_W+1)'(p_hi_r) + (P_W+1)'(p_lo_r >> 16);
  assign dens_nxt  = (dens_full > (P_W+1)'(gsd_pkg::OUT_MAX)) ? gsd_pkg::OUT_MAX
                                                            : dens_full[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_r        <= 1'b0;
      l2_r        <= 1'b0;
      h3_r        <= 1'b0;
      l3_r        <= 1'b0;
      fin_r       <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      h2_r        <= cell_ctl.hit;
      l2_r        <= cell_ctl.last;
      h3_r        <= h2_r;
      l3_r        <= l2_r;
      fin_r       <= l3_r;
      mul_v_r     <= fin_r;
      out_valid_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= cell_term;
    t2_r   <= t2_nxt;
    cube_r <= cube_nxt;
    acc_r  <= acc_nxt;
    if (fin_r) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
      sum_r  <= acc_r;
    end
    if (mul_v_r) begin
      ws_r   <= sum_r;
      dens_r <= dens_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_weight_sum    = ws_r;
  assign out_density_fixed = dens_r;

endmodule

[sv/grid_sph_density_unit.sv]
// Top level of the grid density unit: size registers and block wiring.
//
// Usage: a request is taken at a clock edge where start is high and busy is low.
// in_mode selects a cell write (in_occupied stored at in_x_coord, in_y_coord)
// or a density query centered at that cell. A query returns one result,
// out_weight_sum and out_density_fixed, shown for one cycle with out_valid
// high; a write returns nothing. Results cannot be held off by the receiver.
// Sizes in use are set through cfg_we, cfg_index and cfg_data by the user only
// while idle; the block itself does not enforce this. A write keeps busy high
// through a row read, then a row write back. A query scans the (2*RADIUS+1)^2
// window one cell per cycle from the single read port of the grid memory;
// out_valid rises once the last cell has passed the accumulator pipeline, and
// busy falls in the next cycle. Reset: rst_n clears control and sets both
// sizes to 128; the grid is then cleared one row per cycle with busy high before
// the first request is taken. Configuration writes are taken during that sweep.
module grid_sph_density_unit #(
  parameter int          MAX_COLS  = gsd_pkg::MAX_COLS_DEF,
  parameter int          MAX_ROWS  = gsd_pkg::MAX_ROWS_DEF,
  parameter int          RADIUS    = gsd_pkg::RADIUS_DEF,
  parameter logic [31:0] SCALE_Q32 = gsd_pkg::SCALE_Q32_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [gsd_pkg::COORD_W-1:0]   in_x_coord,
  input  logic [gsd_pkg::COORD_W-1:0]   in_y_coord,
  input  logic                          in_occupied,
  output logic                          out_valid,
  output logic [gsd_pkg::SUM_W-1:0]     out_weight_sum,
  output logic [gsd_pkg::SUM_W-1:0]     out_density_fixed,
  input  logic                          cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CFG_W = gsd_pkg::CFG_W;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int R2    = RADIUS * RADIUS;
  localparam int T_W   = $clog2(R2 + 1);

  logic [CFG_W-1:0]    grid_cols_r, grid_cols_nxt;
  logic [CFG_W-1:0]    grid_rows_r, grid_rows_nxt;
  logic [CFG_W-1:0]    cols_used, rows_used;

  logic                mem_rd_en, mem_wr_en;
  logic [ROW_W-1:0]    mem_rd_addr, mem_wr_addr;
  logic [MAX_COLS-1:0] mem_rd_data, mem_wr_data;
  gsd_pkg::cell_ctl_t  cell_ctl;
  logic [T_W-1:0]      cell_term;

  always_comb begin
    grid_cols_nxt = grid_cols_r;
    grid_rows_nxt = grid_rows_r;
    if (cfg_we) begin
      case (cfg_index)
        gsd_pkg::CFG_IDX_COLS: grid_cols_nxt = cfg_data;
        gsd_pkg::CFG_IDX_ROWS: grid_rows_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= CFG_W'(128);
      grid_rows_r <= CFG_W'(128);
    end else begin
      grid_cols_r <= grid_cols_nxt;
      grid_rows_r <= grid_rows_nxt;
    end
  end

  // A size of zero is used as one; a size beyond the store is used as its size.
  always_comb begin
    cols_used = grid_cols_r;
    if (grid_cols_r == '0) begin
      cols_used = CFG_W'(1);
    end else if (32'(grid_cols_r) > 32'(MAX_COLS)) begin
      cols_used = CFG_W'(MAX_COLS);
    end
    rows_used = grid_rows_r;
    if (grid_rows_r == '0) begin
      rows_used = CFG_W'(1);
    end else if (32'(grid_rows_r) > 32'(MAX_ROWS)) begin
      rows_used = CFG_W'(MAX_ROWS);
    end
  end

  gsd_grid_mem #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  gsd_window_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .RADIUS   (RADIUS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_x_coord  (in_x_coord),
    .in_y_coord  (in_y_coord),
    .in_occupied (in_occupied),
    .cols_used   (cols_used),
    .rows_used   (rows_used),
    .res_done    (out_valid),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .cell_ctl    (cell_ctl),
    .cell_term   (cell_term)
  );

  gsd_accum #(
    .RADIUS    (RADIUS),
    .SCALE_Q32 (SCALE_Q32)
  ) u_acc (
    .clk               (clk),
    .rst_n             (rst_n),
    .cell_ctl          (cell_ctl),
    .cell_term         (cell_term),
    .out_valid         (out_valid),
    .out_weight_sum    (out_weight_sum),
    .out_density_fixed (out_density_fixed)
  );

endmodule

[sv/gsd_checker.sv]
// Port-level checker for the grid density unit and its bind.
`include "grid_sph_density_unit_defines.svh"

module gsd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_mode,
  input logic out_valid
);

  // Every accepted request occupies the block for at least the next cycle.
  `GSD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but busy not raised")

  // A result is strobed for a single cycle only.
  `GSD_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")

  // A result belongs to a query in progress and ends it.
  `GSD_ASSERT_NOW(a_result_busy, out_valid, busy, "result shown while idle")
  `GSD_ASSERT_NEXT(a_result_ends, out_valid, !busy, "block still busy after result")

  // A write request never produces a result right after it.
  `GSD_ASSERT_NEXT(a_write_silent, start && !busy && !in_mode, !out_valid,
                   "result after a write request")

endmodule

bind grid_sph_density_unit gsd_checker u_gsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid)
);
